// File: design/spectral_peak_frequency_picker_defines.svh
// Assertion macros for the spectral peak picker.
`ifndef SPECTRAL_PEAK_FREQUENCY_PICKER_DEFINES_SVH
`define SPECTRAL_PEAK_FREQUENCY_PICKER_DEFINES_SVH

`ifndef SYNTHESIS
`define SPFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spfp: assertion failed");
`define SPFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spfp: assertion failed");
`else
`define SPFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SPFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: design/spfp_pkg.sv
package spfp_pkg;

  localparam int BIN_W      = 9;
  localparam int RANK_W     = 5;
  localparam int FREQ_W     = 17;
  localparam int FL_W       = 4;
  localparam int NF_CFG_W   = 6;
  localparam int SR_W       = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam int NBINS_W    = 10;

  localparam int MAX_BINS_DEF     = 512;
  localparam int MAX_FEATURES_DEF = 32;
  localparam int MAG_WIDTH_DEF    = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LOG2   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_FEATURES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE  = 2'd2;

  localparam logic [FL_W-1:0]     FRAME_LOG2_RST   = 4'd9;
  localparam logic [NF_CFG_W-1:0] NUM_FEATURES_RST = 6'd3;
  localparam logic [SR_W-1:0]     SAMPLE_RATE_RST  = 18'd16000;

  localparam logic [FL_W-1:0] FL_MIN = 4'd2;
  localparam logic [FL_W-1:0] FL_MAX = 4'd10;

  typedef enum logic {
    ST_RUN,
    ST_EMIT
  } spfp_state_t;

  // control broadcast to every cell of the list
  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } spfp_ctl_t;

endpackage

// File: design/spfp_cell.sv
module spfp_cell import spfp_pkg::*; #(
  parameter int MAG_W = MAG_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  spfp_ctl_t        ctl,
  input  logic [MAG_W-1:0] new_mag,
  input  logic [BIN_W-1:0] new_bin,
  input  logic             left_valid,
  input  logic [MAG_W-1:0] left_mag,
  input  logic [BIN_W-1:0] left_bin,
  input  logic             left_take,
  input  logic             right_valid,
  input  logic [MAG_W-1:0] right_mag,
  input  logic [BIN_W-1:0] right_bin,
  output logic             valid,
  output logic [MAG_W-1:0] mag,
  output logic [BIN_W-1:0] bin,
  output logic             take
);

  logic             valid_r;
  logic [MAG_W-1:0] mag_r;
  logic [BIN_W-1:0] bin_r;

  // new word belongs at or above this slot; ties stay behind the older entry
  assign take  = !valid_r || (mag_r < new_mag);
  assign valid = valid_r;
  assign mag   = mag_r;
  assign bin   = bin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.clear) begin
      valid_r <= 1'b0;
    end else if (ctl.shift) begin
      valid_r <= right_valid;
    end else if (ctl.insert) begin
      if (left_take) begin
        valid_r <= left_valid;
      end else if (take) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      mag_r <= right_mag;
      bin_r <= right_bin;
    end else if (ctl.insert) begin
      if (left_take) begin
        mag_r <= left_mag;
        bin_r <= left_bin;
      end else if (take) begin
        mag_r <= new_mag;
        bin_r <= new_bin;
      end
    end
  end

endmodule

// File: design/spectral_peak_frequency_picker.sv
// Channel | Direction | Handshake            | Word
// in_     | input     | in_valid / in_stall   | in_magnitude
// out_    | output    | out_valid / out_stall | out_rank, out_bin_index, out_frequency_hz,
//         |           |                       | out_peak_valid, out_last
// cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One bin is taken per cycle while a frame streams in; a peak is placed in the
// sorted cell row in the same cycle it is found.
// After the last bin the input stalls until num_features results are out, while
// the row shifts toward cell 0, one result per cycle when the output does not stall.
// Frequency is one 9x18 multiply and shift into the output register.
// Reset is synchronous; the list clears in all cells together, no sweep.
`include "spectral_peak_frequency_picker_defines.svh"

module spectral_peak_frequency_picker import spfp_pkg::*; #(
  parameter int MAX_BINS     = MAX_BINS_DEF,
  parameter int MAX_FEATURES = MAX_FEATURES_DEF,
  parameter int MAG_WIDTH    = MAG_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [MAG_WIDTH-1:0]  in_magnitude,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [RANK_W-1:0]     out_rank,
  output logic [BIN_W-1:0]      out_bin_index,
  output logic [FREQ_W-1:0]     out_frequency_hz,
  output logic                  out_peak_valid,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW     = (MAX_BINS > 2) ? $clog2(MAX_BINS) : 1;
  localparam int NFW    = $clog2(MAX_FEATURES + 1);
  localparam int CNT_W  = (NFW > NF_CFG_W) ? NFW : NF_CFG_W;
  localparam int PROD_W = BIN_W + SR_W;

  logic [FL_W-1:0]     frame_log2_r;
  logic [NF_CFG_W-1:0] num_feat_r;
  logic [SR_W-1:0]     sample_rate_r;

  spfp_state_t st_r, st_nxt;

  logic [CW-1:0]        bin_cnt_r;
  logic [MAG_WIDTH-1:0] prev_r, prev2_r;
  logic [CNT_W-1:0]     k_r;

  logic                 out_valid_r, out_peak_valid_r, out_last_r;
  logic [RANK_W-1:0]    out_rank_r;
  logic [BIN_W-1:0]     out_bin_r;
  logic [FREQ_W-1:0]    out_freq_r;

  logic [FL_W-1:0]      fl_sat;
  logic [NBINS_W-1:0]   nbins_raw, nbins, cur10;
  logic [CNT_W-1:0]     nf_ext, nf;
  logic                 in_acc, frame_end, cand_prev, cand_last, emit_load, emit_done;
  logic [MAG_WIDTH-1:0] ins_mag;
  logic [BIN_W-1:0]     ins_bin;
  logic [PROD_W-1:0]    prod;
  spfp_ctl_t            ctl;

  logic                 c_valid [MAX_FEATURES];
  logic [MAG_WIDTH-1:0] c_mag   [MAX_FEATURES];
  logic [BIN_W-1:0]     c_bin   [MAX_FEATURES];
  logic                 c_take  [MAX_FEATURES];
  logic [MAX_FEATURES-1:0] c_valid_vec;
  logic                 cells_packed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_log2_r  <= FRAME_LOG2_RST;
      num_feat_r    <= NUM_FEATURES_RST;
      sample_rate_r <= SAMPLE_RATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_LOG2:   frame_log2_r  <= cfg_data[FL_W-1:0];
        CFG_NUM_FEATURES: num_feat_r    <= cfg_data[NF_CFG_W-1:0];
        CFG_SAMPLE_RATE:  sample_rate_r <= cfg_data[SR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_log2_r < FL_MIN) begin
      fl_sat = FL_MIN;
    end else if (frame_log2_r > FL_MAX) begin
      fl_sat = FL_MAX;
    end else begin
      fl_sat = frame_log2_r;
    end
    nbins_raw = NBINS_W'(1) << (fl_sat - FL_W'(1));
    nbins     = (nbins_raw > NBINS_W'(MAX_BINS)) ? NBINS_W'(MAX_BINS) : nbins_raw;
    cur10     = NBINS_W'(bin_cnt_r);
    nf_ext    = CNT_W'(num_feat_r);
    if (nf_ext == '0) begin
      nf = CNT_W'(1);
    end else if (nf_ext > CNT_W'(MAX_FEATURES)) begin
      nf = CNT_W'(MAX_FEATURES);
    end else begin
      nf = nf_ext;
    end
  end

  assign in_stall  = (st_r != ST_RUN);
  assign in_acc    = in_valid && !in_stall;
  assign frame_end = (cur10 + NBINS_W'(1)) >= nbins;

  // previous bin is a peak once its right neighbor is known
  assign cand_prev = (cur10 != '0) && ((cur10 == NBINS_W'(1)) || (prev_r > prev2_r))
                     && (prev_r > in_magnitude);
  assign cand_last = frame_end && (cur10 != '0) && (in_magnitude > prev_r);
  assign ins_mag   = cand_prev ? prev_r : in_magnitude;
  assign ins_bin   = cand_prev ? (BIN_W'(bin_cnt_r) - BIN_W'(1)) : BIN_W'(bin_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_cnt_r <= '0;
      prev_r    <= '0;
      prev2_r   <= '0;
    end else if (in_acc) begin
      if (frame_end) begin
        bin_cnt_r <= '0;
        prev_r    <= '0;
        prev2_r   <= '0;
      end else begin
        bin_cnt_r <= CW'(cur10 + NBINS_W'(1));
        prev_r    <= in_magnitude;
        prev2_r   <= prev_r;
      end
    end
  end

  assign emit_load = (st_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign emit_done = emit_load && (k_r == nf - CNT_W'(1));

  always_comb begin
    st_nxt     = st_r;
    ctl.insert = in_acc && (cand_prev || cand_last);
    ctl.shift  = emit_load && !emit_done;
    ctl.clear  = emit_done;
    unique case (st_r)
      ST_RUN:  if (in_acc && frame_end) st_nxt = ST_EMIT;
      ST_EMIT: if (emit_done) st_nxt = ST_RUN;
      default: st_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RUN;
      k_r  <= '0;
    end else begin
      st_r <= st_nxt;
      if (emit_done) begin
        k_r <= '0;
      end else if (emit_load) begin
        k_r <= k_r + CNT_W'(1);
      end
    end
  end

  for (genvar i = 0; i < MAX_FEATURES; i++) begin : g_cell
    logic             l_valid, l_take, r_valid;
    logic [MAG_WIDTH-1:0] l_mag, r_mag;
    logic [BIN_W-1:0] l_bin, r_bin;

    if (i == 0) begin : g_head
      assign l_valid = 1'b0;
      assign l_mag   = '0;
      assign l_bin   = '0;
      assign l_take  = 1'b0;
    end else begin : g_link_l
      assign l_valid = c_valid[i-1];
      assign l_mag   = c_mag[i-1];
      assign l_bin   = c_bin[i-1];
      assign l_take  = c_take[i-1];
    end

    if (i == MAX_FEATURES - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_mag   = '0;
      assign r_bin   = '0;
    end else begin : g_link_r
      assign r_valid = c_valid[i+1];
      assign r_mag   = c_mag[i+1];
      assign r_bin   = c_bin[i+1];
    end

    spfp_cell #(
      .MAG_W (MAG_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .new_mag     (ins_mag),
      .new_bin     (ins_bin),
      .left_valid  (l_valid),
      .left_mag    (l_mag),
      .left_bin    (l_bin),
      .left_take   (l_take),
      .right_valid (r_valid),
      .right_mag   (r_mag),
      .right_bin   (r_bin),
      .valid       (c_valid[i]),
      .mag         (c_mag[i]),
      .bin         (c_bin[i]),
      .take        (c_take[i])
    );

    assign c_valid_vec[i] = c_valid[i];
  end

  assign prod = PROD_W'(c_bin[0]) * PROD_W'(sample_rate_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_rank_r       <= RANK_W'(k_r);
      out_last_r       <= (k_r == nf - CNT_W'(1));
      out_peak_valid_r <= c_valid[0];
      out_bin_r        <= c_valid[0] ? c_bin[0] : '0;
      out_freq_r       <= c_valid[0] ? FREQ_W'(prod >> fl_sat) : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_rank         = out_rank_r;
  assign out_bin_index    = out_bin_r;
  assign out_frequency_hz = out_freq_r;
  assign out_peak_valid   = out_peak_valid_r;
  assign out_last         = out_last_r;

  // filled cells form an unbroken run from cell 0
  assign cells_packed = ((c_valid_vec + MAX_FEATURES'(1)) & c_valid_vec) == '0;

  `SPFP_ASSERT_IMP(a_cells_prefix, clk, rst_n, 1'b1, cells_packed)
  `SPFP_ASSERT_NXT(a_frame_end_stalls, clk, rst_n, in_acc && frame_end, in_stall)
  `SPFP_ASSERT_IMP(a_list_empty_after_emit, clk, rst_n, $fell(in_stall), c_valid_vec == '0)

endmodule

// File: sim/tb_spectral_peak_frequency_picker.sv
module tb_spectral_peak_frequency_picker;
  timeunit 1ns;
  timeprecision 1ps;
  import spfp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int {SHAPE_WIDE, SHAPE_SMALL, SHAPE_ZIGZAG} shape_t;

  typedef struct {
    bit [RANK_W-1:0] rank;
    bit [BIN_W-1:0]  bin_index;
    bit [FREQ_W-1:0] frequency_hz;
    bit              peak_valid;
    bit              last;
  } peak_word_t;

  class peak_tracker;
    bit [FL_W-1:0]     frame_log2_q;
    bit [NF_CFG_W-1:0] features_q;
    bit [SR_W-1:0]     rate_q;
    bit [BIN_W-1:0]    bin_pos;
    bit [31:0]         last_mag;
    bit [31:0]         older_mag;
    bit [31:0]         list_mag [MAX_FEATURES_DEF];
    bit [BIN_W-1:0]    list_bin [MAX_FEATURES_DEF];
    int unsigned       list_len;
    peak_word_t        due_peaks [$];
    int unsigned       bins_taken;
    int unsigned       words_checked;
    bit                broken;

    function new();
      frame_log2_q = FRAME_LOG2_RST;
      features_q = NUM_FEATURES_RST;
      rate_q = SAMPLE_RATE_RST;
      clear_frame();
    endfunction

    function void clear_frame();
      bin_pos = '0;
      last_mag = '0;
      older_mag = '0;
      list_len = 0;
      for (int i = 0; i < MAX_FEATURES_DEF; i++) begin
        list_mag[i] = '0;
        list_bin[i] = '0;
      end
    endfunction

    function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_FRAME_LOG2:   frame_log2_q = val[FL_W-1:0];
        CFG_NUM_FEATURES: features_q = val[NF_CFG_W-1:0];
        CFG_SAMPLE_RATE:  rate_q = val[SR_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_log2();
      if (frame_log2_q < FL_MIN) return FL_MIN;
      if (frame_log2_q > FL_MAX) return FL_MAX;
      return frame_log2_q;
    endfunction

    function int unsigned bins_left();
      int unsigned b;
      b = 1 << (eff_log2() - 1);
      return (bin_pos < b) ? b - bin_pos : 1;
    endfunction

    function int unsigned pending();
      return due_peaks.size();
    endfunction

    function void insert_peak(bit [31:0] mag, bit [BIN_W-1:0] bin);
      int unsigned pos;
      int unsigned j;
      pos = 0;
      while (pos < list_len && list_mag[pos] >= mag) pos++;
      if (pos >= MAX_FEATURES_DEF) return;
      j = (list_len < MAX_FEATURES_DEF) ? list_len : MAX_FEATURES_DEF - 1;
      while (j > pos) begin
        list_mag[j] = list_mag[j-1];
        list_bin[j] = list_bin[j-1];
        j--;
      end
      list_mag[pos] = mag;
      list_bin[pos] = bin;
      if (list_len < MAX_FEATURES_DEF) list_len++;
    endfunction

    function void take_bin(bit [31:0] m);
      int unsigned lg;
      int unsigned nbins;
      int unsigned nf;
      int unsigned cur;
      longint unsigned f;
      peak_word_t w;
      bins_taken++;
      lg = eff_log2();
      nbins = 1 << (lg - 1);
      cur = bin_pos;
      if (cur >= 1) begin
        if ((cur == 1 || last_mag > older_mag) && last_mag > m)
          insert_peak(last_mag, BIN_W'(cur - 1));
      end
      if (cur + 1 < nbins) begin
        older_mag = last_mag;
        last_mag = m;
        bin_pos = BIN_W'(cur + 1);
        return;
      end
      if (cur >= 1 && m > last_mag) insert_peak(m, BIN_W'(cur));
      nf = features_q;
      if (nf < 1) nf = 1;
      if (nf > MAX_FEATURES_DEF) nf = MAX_FEATURES_DEF;
      for (int unsigned k = 0; k < nf; k++) begin
        w.rank = RANK_W'(k);
        if (k < list_len) begin
          f = (64'(list_bin[k]) * 64'(rate_q)) >> lg;
          w.bin_index = list_bin[k];
          w.frequency_hz = f[FREQ_W-1:0];
          w.peak_valid = 1'b1;
        end else begin
          w.bin_index = '0;
          w.frequency_hz = '0;
          w.peak_valid = 1'b0;
        end
        w.last = (k + 1 == nf);
        due_peaks.push_back(w);
      end
      clear_frame();
    endfunction

    function void check_peak(peak_word_t got);
      peak_word_t want;
      words_checked++;
      if (due_peaks.size() == 0) begin
        $error("unexpected peak word: rank %0d bin_index %0d", got.rank, got.bin_index);
        broken = 1'b1;
        return;
      end
      want = due_peaks.pop_front();
      if (got.rank != want.rank) begin
        $error("rank: expected %0d, got %0d", want.rank, got.rank);
        broken = 1'b1;
      end
      if (got.bin_index != want.bin_index) begin
        $error("bin_index: expected %0d, got %0d", want.bin_index, got.bin_index);
        broken = 1'b1;
      end
      if (got.frequency_hz != want.frequency_hz) begin
        $error("frequency_hz: expected %0d, got %0d", want.frequency_hz, got.frequency_hz);
        broken = 1'b1;
      end
      if (got.peak_valid != want.peak_valid) begin
        $error("peak_valid: expected %0d, got %0d", want.peak_valid, got.peak_valid);
        broken = 1'b1;
      end
      if (got.last != want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        broken = 1'b1;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [31:0]           in_magnitude = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [RANK_W-1:0]     out_rank;
  logic [BIN_W-1:0]      out_bin_index;
  logic [FREQ_W-1:0]     out_frequency_hz;
  logic                  out_peak_valid;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned tx_idle_pct = 31;
  int unsigned rx_idle_pct = 54;

  peak_tracker sb = new();

  spectral_peak_frequency_picker dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_magnitude     (in_magnitude),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rank         (out_rank),
    .out_bin_index    (out_bin_index),
    .out_frequency_hz (out_frequency_hz),
    .out_peak_valid   (out_peak_valid),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    peak_word_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.rank = out_rank;
      seen.bin_index = out_bin_index;
      seen.frequency_hz = out_frequency_hz;
      seen.peak_valid = out_peak_valid;
      seen.last = out_last;
      sb.check_peak(seen);
    end
  end

  task automatic send_bin(input bit [31:0] m);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_magnitude <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_bin(m);
  endtask

  task automatic send_frame(input int unsigned n, input shape_t shape);
    bit [31:0] m;
    for (int unsigned i = 0; i < n; i++) begin
      case (shape)
        SHAPE_SMALL:  m = $urandom_range(3);
        SHAPE_ZIGZAG: m = i[0] ? $urandom_range(32'hFF) : $urandom_range(32'hFFFFFFFE, 32'h100);
        default:      m = $urandom();
      endcase
      send_bin(m);
    end
  endtask

  // drain: wait until every due peak is seen, then let the list settle
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input bit [CFG_IDX_W-1:0] idx, input bit [CFG_DATA_W-1:0] val,
                           input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    if (!more) cfg_valid <= 1'b0;
  endtask

  task automatic pick_settings();
    bit [CFG_DATA_W-1:0] fl;
    bit [CFG_DATA_W-1:0] nf;
    bit [CFG_DATA_W-1:0] sr;
    fl = CFG_DATA_W'(($urandom_range(7) == 0) ? $urandom_range(1) : $urandom_range(5, 2));
    case ($urandom_range(7))
      0:       nf = CFG_DATA_W'($urandom_range(1) ? 0 : $urandom_range(63, 33));
      1:       nf = 32;
      default: nf = CFG_DATA_W'($urandom_range(32, 1));
    endcase
    case ($urandom_range(7))
      0:       sr = 0;
      1:       sr = $urandom_range(1) ? 18'h3FFFF : 18'd192000;
      default: sr = CFG_DATA_W'($urandom_range(192000, 1));
    endcase
    wait_quiet();
    write_reg(CFG_FRAME_LOG2, fl, 1'b1);
    write_reg(CFG_NUM_FEATURES, nf, 1'b1);
    write_reg(CFG_SAMPLE_RATE, sr, 1'b0);
  endtask

  initial begin
    int unsigned bins_goal;
    int unsigned words_goal;
    int unsigned guard;
    shape_t shape;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: 256-bin frame, cut short by shrinking the frame
    send_bin(0); send_bin(9); send_bin(4);
    wait_quiet();
    write_reg(CFG_FRAME_LOG2, 2, 1'b0);
    send_bin(1);

    send_bin(0); send_bin(0);
    send_bin(32'hFFFFFFFF); send_bin(0);
    send_bin(5); send_bin(32'hFFFFFFFF);
    send_bin(7); send_bin(7);

    wait_quiet();
    write_reg(CFG_SPARE, 18'h3FFFF, 1'b1);
    write_reg(CFG_FRAME_LOG2, 3, 1'b1);
    write_reg(CFG_NUM_FEATURES, 1, 1'b1);
    write_reg(CFG_SAMPLE_RATE, 1, 1'b0);
    send_bin(8); send_bin(1); send_bin(8); send_bin(1);
    send_bin(1); send_bin(6); send_bin(2); send_bin(9);

    wait_quiet();
    write_reg(CFG_NUM_FEATURES, 4, 1'b1);
    write_reg(CFG_SAMPLE_RATE, 192000, 1'b0);
    send_bin(8); send_bin(1); send_bin(8); send_bin(1);

    wait_quiet();
    write_reg(CFG_SAMPLE_RATE, 0, 1'b1);
    write_reg(CFG_FRAME_LOG2, 0, 1'b1);
    write_reg(CFG_NUM_FEATURES, 0, 1'b0);
    send_bin(2); send_bin(1);

    // oversized frame setting: peak list overflows, then a shrunk frame ends
    // on a bin that becomes the strongest peak
    wait_quiet();
    write_reg(CFG_FRAME_LOG2, 15, 1'b1);
    write_reg(CFG_NUM_FEATURES, 63, 1'b1);
    write_reg(CFG_SAMPLE_RATE, 18'h3FFFF, 1'b0);
    send_frame(70, SHAPE_ZIGZAG);
    wait_quiet();
    write_reg(CFG_FRAME_LOG2, 2, 1'b0);
    send_bin(32'hFFFFFFFF);

    bins_goal = sb.bins_taken + 20;
    words_goal = sb.words_checked + 12;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 31; rx_idle_pct = 54; end
        1: begin tx_idle_pct = 54; rx_idle_pct = 31; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      while (sb.bins_taken < bins_goal || sb.words_checked < words_goal) begin
        shape = shape_t'($urandom_range(2));
        if ($urandom_range(1)) pick_settings();
        if ($urandom_range(9) == 0 && sb.bins_left() > 1) begin
          send_frame($urandom_range(sb.bins_left() - 1, 1), shape);
          pick_settings();
        end
        send_frame(sb.bins_left(), shape);
      end
      bins_goal += 20;
      words_goal += 12;
    end

    in_valid <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected peak words never arrived", sb.pending());
      sb.broken = 1'b1;
    end
    if (!sb.broken) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout waiting on the peak picker");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: spectral_peak_frequency_picker.f
+incdir+design
design/spfp_pkg.sv
design/spfp_cell.sv
design/spectral_peak_frequency_picker.sv
sim/tb_spectral_peak_frequency_picker.sv
